@@ rtl/dns_query_packet_builder_assert.svh @@
// Assertion macros for the DNS query packet builder.
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
`ifndef DNS_QUERY_PACKET_BUILDER_ASSERT_SVH
`define DNS_QUERY_PACKET_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
`define DQPB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("dqpb assertion failed");
`define DQPB_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("dqpb forbidden condition");
`else
`define DQPB_ASSERT(lbl, clk, rstn, prop)
`define DQPB_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ rtl/dqpb_pkg.sv @@
// Shared types and constants of the DNS query packet builder.
// No dependencies.
package dqpb_pkg;

  localparam int LABEL_CAPACITY = 32;
  localparam int CNT_W          = $clog2(LABEL_CAPACITY + 1);
  localparam int HDR_BYTES      = 12;
  localparam int HDR_QDCOUNT_LO = 5;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] QDCOUNT_1 = 8'h01;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS = 1'b1;

  typedef struct packed {
    logic [7:0] name_char;
    logic       end_of_name;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
    logic       label_overflow;
  } out_beat_t;

  // control from the sequencer to the label chain
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] load_idx;
    logic             shift;
  } chain_ctl_t;

endpackage

@@ rtl/dqpb_cell.sv @@
// One byte cell of the label chain.
// Depends on dqpb_pkg (imported for the house convention).
module dqpb_cell
  import dqpb_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_data,
  input  logic       shift,
  input  logic [7:0] from_next,
  output logic [7:0] data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ rtl/dqpb_chain.sv @@
// Row of label cells: chars load at the fill position, drain by shifting toward cell 0.
// Depends on dqpb_pkg and dqpb_cell.
module dqpb_chain
  import dqpb_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  input  logic [7:0] load_data,
  output logic [7:0] head
);

  logic [7:0] cell_q [LABEL_CAPACITY];
  logic [7:0] cell_in [LABEL_CAPACITY];

  for (genvar i = 0; i < LABEL_CAPACITY; i++) begin : g_cell
    if (i == LABEL_CAPACITY - 1) begin : g_tail
      assign cell_in[i] = 8'h00;
    end else begin : g_mid
      assign cell_in[i] = cell_q[i+1];
    end

    dqpb_cell u_cell (
      .clk       (clk),
      .load      (ctl.load && (ctl.load_idx == CNT_W'(i))),
      .load_data (load_data),
      .shift     (ctl.shift),
      .from_next (cell_in[i]),
      .data      (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

@@ rtl/dns_query_packet_builder.sv @@
// Top level of the DNS query packet builder: sequencer, config registers, output register.
// Depends on dqpb_pkg, dqpb_chain and dns_query_packet_builder_assert.svh.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------------
//  in      | in_valid, in_stall, in_data    | in_beat_t: name_char, end_of_name
//  out     | out_valid, out_stall, out_data | out_beat_t: byte, last, overflow
//  cfg     | cfg_we, cfg_index, cfg_wdata   | query_type (0), query_class (1)
//
// A plain character is written straight into the label chain unless the chain is full.
// A name's first beat adds 12 header bytes; a dot adds 1 + label length bytes;
// end of name adds the flushed label, terminator, type and class (5 bytes).
// Every output byte passes through the output register; out_stall holds it there.
// in_stall is high while the sequencer is emitting bytes for the last beat.
// Reset (rst_n low, synchronous) clears control state; label bytes are not cleared.
`include "dns_query_packet_builder_assert.svh"

module dns_query_packet_builder
  import dqpb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  localparam logic [2:0] TAIL_LAST = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       hdr_idx_r, hdr_idx_nxt;
  logic [2:0]       tail_idx_r, tail_idx_nxt;
  logic [CNT_W-1:0] label_cnt_r, label_cnt_nxt;
  logic             hdr_sent_r, hdr_sent_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pend_end_r, pend_end_nxt;
  logic             pend_dot_r, pend_dot_nxt;
  logic [15:0]      qtype_r, qclass_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic       accept;
  logic       fire;
  logic       is_dot;
  logic       is_char;
  logic [7:0] head;
  chain_ctl_t ctl;
  logic [2:0] after_hdr;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_dot   = !in_data.end_of_name && (in_data.name_char == DOT_CHAR);
  assign is_char  = !in_data.end_of_name && !is_dot;

  // one output byte per cycle while the output register can take it
  assign fire = (state_r != S_IDLE) && (!out_valid_r || !out_stall);

  assign ctl.load     = accept && is_char && (label_cnt_r < CNT_W'(LABEL_CAPACITY));
  assign ctl.load_idx = label_cnt_r;
  assign ctl.shift    = fire && (state_r == S_DATA);

  dqpb_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .load_data (in_data.name_char),
    .head      (head)
  );

  // where the name's work goes once the header (if any) is out
  always_comb begin
    if (pend_end_r) begin
      after_hdr = ((label_cnt_r != '0) || ovf_r) ? S_LEN : S_TAIL;
    end else if (pend_dot_r) begin
      after_hdr = S_LEN;
    end else begin
      after_hdr = S_IDLE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hdr_idx_nxt   = hdr_idx_r;
    tail_idx_nxt  = tail_idx_r;
    label_cnt_nxt = label_cnt_r;
    hdr_sent_nxt  = hdr_sent_r;
    ovf_nxt       = ovf_r;
    pend_end_nxt  = pend_end_r;
    pend_dot_nxt  = pend_dot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (accept) begin
      pend_end_nxt = in_data.end_of_name;
      pend_dot_nxt = is_dot;
      hdr_idx_nxt  = '0;
      tail_idx_nxt = '0;
      if (ctl.load) begin
        label_cnt_nxt = label_cnt_r + CNT_W'(1);
      end else if (is_char) begin
        ovf_nxt = 1'b1;
      end
      if (!hdr_sent_r) begin
        state_nxt = S_HDR;
      end else if (in_data.end_of_name) begin
        state_nxt = ((label_cnt_r != '0) || ovf_r) ? S_LEN : S_TAIL;
      end else if (is_dot) begin
        state_nxt = S_LEN;
      end else begin
        state_nxt = S_IDLE;
      end
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      case (state_r)
        S_HDR: begin
          out_data_nxt.out_byte = (hdr_idx_r == 4'(HDR_QDCOUNT_LO)) ? QDCOUNT_1 : 8'h00;
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_r == 4'(HDR_BYTES - 1)) begin
            hdr_sent_nxt = 1'b1;
            state_nxt    = after_hdr;
          end
        end
        S_LEN: begin
          out_data_nxt.out_byte       = 8'(label_cnt_r);
          out_data_nxt.label_overflow = ovf_r;
          ovf_nxt = 1'b0;
          if (label_cnt_r != '0) begin
            state_nxt = S_DATA;
          end else begin
            state_nxt = pend_end_r ? S_TAIL : S_IDLE;
          end
        end
        S_DATA: begin
          out_data_nxt.out_byte = head;
          label_cnt_nxt = label_cnt_r - CNT_W'(1);
          if (label_cnt_r == CNT_W'(1)) begin
            state_nxt = pend_end_r ? S_TAIL : S_IDLE;
          end
        end
        S_TAIL: begin
          tail_idx_nxt = tail_idx_r + 3'd1;
          case (tail_idx_r)
            3'd0:    out_data_nxt.out_byte = 8'h00;
            3'd1:    out_data_nxt.out_byte = qtype_r[15:8];
            3'd2:    out_data_nxt.out_byte = qtype_r[7:0];
            3'd3:    out_data_nxt.out_byte = qclass_r[15:8];
            default: out_data_nxt.out_byte = qclass_r[7:0];
          endcase
          if (tail_idx_r == TAIL_LAST) begin
            out_data_nxt.last_of_packet = 1'b1;
            hdr_sent_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hdr_idx_r   <= '0;
      tail_idx_r  <= '0;
      label_cnt_r <= '0;
      hdr_sent_r  <= 1'b0;
      ovf_r       <= 1'b0;
      pend_end_r  <= 1'b0;
      pend_dot_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      tail_idx_r  <= tail_idx_nxt;
      label_cnt_r <= label_cnt_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      ovf_r       <= ovf_nxt;
      pend_end_r  <= pend_end_nxt;
      pend_dot_r  <= pend_dot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // config registers, reset to A / IN
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qtype_r  <= 16'h0001;
      qclass_r <= 16'h0001;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_TYPE:  qtype_r  <= cfg_wdata;
        CFG_QUERY_CLASS: qclass_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // label fill never passes the chain length
  `DQPB_NEVER(a_cnt_cap, clk, rst_n, label_cnt_r > CNT_W'(LABEL_CAPACITY))
  // draining state always has a byte left in the chain
  `DQPB_NEVER(a_data_nonempty, clk, rst_n, (state_r == S_DATA) && (label_cnt_r == '0))
  // closing class byte ends the packet: next beat starts with a fresh header
  `DQPB_ASSERT(a_tail_rearm, clk, rst_n,
    (fire && (state_r == S_TAIL) && (tail_idx_r == TAIL_LAST)) |=> !hdr_sent_r)

endmodule
